// ===== sv/hpss_pkg.sv =====
// ----------------------------------------------------------------------------
// hpss_pkg
// Shared constants, types and helpers of the heat plate stencil stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package hpss_pkg;

    // Grid geometry.
    localparam int GRID_SIZE = 32;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int RC_W      = $clog2(GRID_SIZE);

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 5;
    localparam int VAL_W      = 24;
    localparam int GAIN_W     = 15;
    localparam int STEPS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths: four neighbors minus four times the center, then the gain.
    localparam int FRAC_W = 16;
    localparam int LAP_W  = VAL_W + 4;
    localparam int PROD_W = LAP_W + GAIN_W + 1;

    // Sweep of a time step: reads run GRID_SIZE cells ahead of the updated cell.
    localparam int PIPE_DEPTH = 4;
    localparam int LAST_PUSH  = CELLS + GRID_SIZE - 1;
    localparam int SWEEP_LAST = LAST_PUSH + PIPE_DEPTH;
    localparam int SWEEP_W    = $clog2(SWEEP_LAST + 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_FILL = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_STEP = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_READ = CMD_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LEFT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR = CFG_IDX_W'(5);

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
    localparam logic [VAL_W-1:0]  SIDE_RESET = VAL_W'(6553600);

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [SWEEP_W-1:0]      sweep_t;
    typedef logic [RC_W-1:0]         rc_t;

    // One source cell arriving from the memory during a time step.
    typedef struct packed {
        logic   valid;
        sweep_t idx;
    } push_t;

    // One write request toward a grid bank.
    typedef struct packed {
        logic  en;
        addr_t addr;
        val_t  data;
    } wreq_t;

    // Row and column of a cell address.
    function automatic rc_t addr_row(addr_t a);
        return rc_t'(int'(a) / GRID_SIZE);
    endfunction

    function automatic rc_t addr_col(addr_t a);
        return rc_t'(int'(a) % GRID_SIZE);
    endfunction

endpackage

`default_nettype wire

// ===== sv/hpss_bank.sv =====
// ----------------------------------------------------------------------------
// hpss_bank
// One grid bank: a single-port-write, single-port-read memory with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hpss_bank (
    input  logic           aclk,
    input  logic           we,
    input  hpss_pkg::addr_t waddr,
    input  hpss_pkg::val_t  wdata,
    input  hpss_pkg::addr_t raddr,
    output hpss_pkg::val_t  rdata
);
    import hpss_pkg::*;

    val_t cells_mem [0:CELLS-1];
    val_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            cells_mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= cells_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/hpss_stencil.sv =====
// ----------------------------------------------------------------------------
// hpss_stencil
// Five-point stencil datapath: a line of two rows plus one cell holds the
// neighbors of the cell being updated; the update runs in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hpss_stencil (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hpss_pkg::push_t             push,
    input  hpss_pkg::val_t              rd_data,
    input  logic [hpss_pkg::GAIN_W-1:0] gain,
    output hpss_pkg::wreq_t             wr
);
    import hpss_pkg::*;

    localparam int LINE_LEN = 2 * GRID_SIZE + 1;
    localparam logic signed [LAP_W:0] SAT_HI = (LAP_W + 1)'(2 ** (VAL_W - 1) - 1);
    localparam logic signed [LAP_W:0] SAT_LO = -(LAP_W + 1)'(2 ** (VAL_W - 1));

    // Line of source cells, newest at tap zero.
    val_t   line_reg [0:LINE_LEN-1];
    logic   a_valid_reg;
    sweep_t a_idx_reg;

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            line_reg[0] <= rd_data;
            for (int i = 1; i < LINE_LEN; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= push.valid;
        end
    end

    always_ff @(posedge aclk) begin
        a_idx_reg <= push.idx;
    end

    // Stage A: the center sits GRID_SIZE cells behind the newest cell.
    logic                    a_live;
    addr_t                   a_addr;
    rc_t                     a_row;
    rc_t                     a_col;
    logic                    a_rim;
    logic signed [LAP_W-1:0] a_lap;
    val_t                    a_u;

    always_comb begin
        a_live = a_valid_reg && (a_idx_reg >= SWEEP_W'(GRID_SIZE));
        a_addr = addr_t'(a_idx_reg - SWEEP_W'(GRID_SIZE));
        a_row  = addr_row(a_addr);
        a_col  = addr_col(a_addr);
        a_rim  = (a_row == rc_t'(0)) || (a_row == rc_t'(GRID_SIZE - 1)) ||
                 (a_col == rc_t'(0)) || (a_col == rc_t'(GRID_SIZE - 1));
        a_u    = line_reg[GRID_SIZE];
        a_lap  = LAP_W'(line_reg[0]) + LAP_W'(line_reg[2*GRID_SIZE])
               + LAP_W'(line_reg[GRID_SIZE-1]) + LAP_W'(line_reg[GRID_SIZE+1])
               - (LAP_W'(a_u) <<< 2);
    end

    logic                    b_valid_reg;
    addr_t                   b_addr_reg;
    logic                    b_rim_reg;
    val_t                    b_u_reg;
    logic signed [LAP_W-1:0] b_lap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_live;
        end
    end

    always_ff @(posedge aclk) begin
        b_addr_reg <= a_addr;
        b_rim_reg  <= a_rim;
        b_u_reg    <= a_u;
        b_lap_reg  <= a_lap;
    end

    // Stage B: gain times the Laplacian.
    logic signed [PROD_W-1:0] b_prod;

    assign b_prod = PROD_W'($signed({1'b0, gain})) * PROD_W'(b_lap_reg);

    logic                     c_valid_reg;
    addr_t                    c_addr_reg;
    logic                     c_rim_reg;
    val_t                     c_u_reg;
    logic signed [PROD_W-1:0] c_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        c_addr_reg <= b_addr_reg;
        c_rim_reg  <= b_rim_reg;
        c_u_reg    <= b_u_reg;
        c_prod_reg <= b_prod;
    end

    // Stage C: drop the fraction (floor), add to the center and saturate.
    logic signed [LAP_W-1:0] c_delta;
    logic signed [LAP_W:0]   c_total;
    val_t                    c_sat;

    always_comb begin
        c_delta = c_prod_reg[PROD_W-1:FRAC_W];
        c_total = (LAP_W + 1)'(c_u_reg) + (LAP_W + 1)'(c_delta);
        if (c_total > SAT_HI) begin
            c_sat = val_t'(SAT_HI);
        end else if (c_total < SAT_LO) begin
            c_sat = val_t'(SAT_LO);
        end else begin
            c_sat = c_total[VAL_W-1:0];
        end
    end

    // Boundary cells are copied unchanged.
    assign wr.en   = c_valid_reg;
    assign wr.addr = c_addr_reg;
    assign wr.data = c_rim_reg ? c_u_reg : c_sat;

endmodule

`default_nettype wire

// ===== sv/heat_plate_stencil_stepper.sv =====
// ----------------------------------------------------------------------------
// heat_plate_stencil_stepper
// Explicit 2-D heat equation on a square plate held in two memory banks.
// Input requests (s_cmd, s_row, s_col) arrive on a valid/ready channel and
// each produces exactly one result (m_cell_value, m_steps_done) on the
// m_ channel. Register writes use the cfg_ channel, always ready; the user
// must make them while the block is idle, which the block does not enforce.
// Work per request, from acceptance to the result register:
//   fill     one cell written per cycle, then the finish state.
//   step     one source read per cycle from the present bank, the stencil
//            pipeline writing the other bank; the sweep over the memory sets
//            the rate, then the bank swap and the finish state.
//   read     the registered memory read, a wait state, then the finish state.
//   other    straight to the finish state.
// One request is worked at a time; s_ready is high only when the block is
// idle. A finished result waits in the output register while the next
// request is taken; a stalled receiver holds the block in its last state
// until the output register frees up. Reset selects bank A, clears the step
// count and the output valid, and loads the register reset values; the grid
// contents are undefined until a fill.
// ----------------------------------------------------------------------------
`default_nettype none

module heat_plate_stencil_stepper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [hpss_pkg::CMD_W-1:0]      s_cmd,
    input  logic [hpss_pkg::COORD_W-1:0]    s_row,
    input  logic [hpss_pkg::COORD_W-1:0]    s_col,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [hpss_pkg::VAL_W-1:0] m_cell_value,
    output logic [hpss_pkg::STEPS_W-1:0]    m_steps_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hpss_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILL   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Configuration registers.
    logic [GAIN_W-1:0] gain_reg;
    val_t              top_reg;
    val_t              bottom_reg;
    val_t              left_reg;
    val_t              right_reg;
    val_t              interior_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            top_reg      <= '0;
            bottom_reg   <= '0;
            left_reg     <= SIDE_RESET;
            right_reg    <= SIDE_RESET;
            interior_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_TOP:      top_reg      <= cfg_data[VAL_W-1:0];
                REG_BOTTOM:   bottom_reg   <= cfg_data[VAL_W-1:0];
                REG_LEFT:     left_reg     <= cfg_data[VAL_W-1:0];
                REG_RIGHT:    right_reg    <= cfg_data[VAL_W-1:0];
                REG_INTERIOR: interior_reg <= cfg_data[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state.
    logic [2:0]         state_reg, state_next;
    sweep_t             count_reg, count_next;
    logic               cur_bank_reg, cur_bank_next;
    logic [STEPS_W-1:0] step_count_reg, step_count_next;
    logic               rd_ok_reg, rd_ok_next;
    val_t               res_cell_reg, res_cell_next;
    logic               m_valid_reg, m_valid_next;
    val_t               m_cell_reg, m_cell_next;
    logic [STEPS_W-1:0] m_steps_reg, m_steps_next;
    push_t              push_reg, push_next;

    // Memory-side signals.
    val_t  a_rdata;
    val_t  b_rdata;
    val_t  rd_data_cur;
    addr_t rd_addr;
    wreq_t st_wr;
    logic  wr_en;
    logic  wr_sel;
    addr_t wr_addr;
    val_t  wr_data;
    val_t  fill_value;
    rc_t   fill_row;
    rc_t   fill_col;
    logic  out_free;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cell_value = m_cell_reg;
    assign m_steps_done = m_steps_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign rd_data_cur  = cur_bank_reg ? b_rdata : a_rdata;

    // Read address: the requested cell while idle, the sweep position otherwise.
    assign rd_addr = (state_reg == ST_IDLE)
                   ? addr_t'(int'(s_row) * GRID_SIZE + int'(s_col))
                   : count_reg[ADDR_W-1:0];

    // Fill pattern; later rules override earlier ones.
    always_comb begin
        fill_row   = addr_row(count_reg[ADDR_W-1:0]);
        fill_col   = addr_col(count_reg[ADDR_W-1:0]);
        fill_value = interior_reg;
        if (fill_row == rc_t'(GRID_SIZE - 1)) begin
            fill_value = top_reg;
        end
        if (fill_col == rc_t'(0) && fill_row != rc_t'(GRID_SIZE - 1)) begin
            fill_value = left_reg;
        end
        if (fill_row == rc_t'(0)) begin
            fill_value = bottom_reg;
        end
        if (fill_col == rc_t'(GRID_SIZE - 1) && fill_row != rc_t'(GRID_SIZE - 1)) begin
            fill_value = right_reg;
        end
    end

    // Write steering: a fill writes the present bank, a step the other one.
    always_comb begin
        if (state_reg == ST_FILL) begin
            wr_en   = 1'b1;
            wr_sel  = cur_bank_reg;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = fill_value;
        end else begin
            wr_en   = st_wr.en;
            wr_sel  = !cur_bank_reg;
            wr_addr = st_wr.addr;
            wr_data = st_wr.data;
        end
    end

    hpss_bank u_bank_a (
        .aclk  (aclk),
        .we    (wr_en && !wr_sel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    hpss_bank u_bank_b (
        .aclk  (aclk),
        .we    (wr_en && wr_sel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    hpss_stencil u_stencil (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_reg),
        .rd_data (rd_data_cur),
        .gain    (gain_reg),
        .wr      (st_wr)
    );

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_bank_next   = cur_bank_reg;
        step_count_next = step_count_reg;
        rd_ok_next      = rd_ok_reg;
        res_cell_next   = res_cell_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_next     = m_cell_reg;
        m_steps_next    = m_steps_reg;
        push_next.valid = (state_reg == ST_STEP) && (count_reg <= SWEEP_W'(LAST_PUSH));
        push_next.idx   = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    count_next    = '0;
                    res_cell_next = '0;
                    rd_ok_next    = (int'(s_row) < GRID_SIZE) && (int'(s_col) < GRID_SIZE);
                    unique case (s_cmd)
                        CMD_FILL: state_next = ST_FILL;
                        CMD_STEP: state_next = ST_STEP;
                        CMD_READ: state_next = ST_RDWAIT;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FILL: begin
                if (count_reg == SWEEP_W'(CELLS - 1)) begin
                    step_count_next = '0;
                    state_next      = ST_FINISH;
                end else begin
                    count_next = count_reg + SWEEP_W'(1);
                end
            end
            ST_STEP: begin
                if (count_reg == SWEEP_W'(SWEEP_LAST)) begin
                    cur_bank_next = !cur_bank_reg;
                    if (step_count_reg != '1) begin
                        step_count_next = step_count_reg + STEPS_W'(1);
                    end
                    state_next = ST_FINISH;
                end else begin
                    count_next = count_reg + SWEEP_W'(1);
                end
            end
            ST_RDWAIT: begin
                res_cell_next = rd_ok_reg ? rd_data_cur : '0;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_cell_next  = res_cell_reg;
                    m_steps_next = step_count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cur_bank_reg    <= 1'b0;
            step_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
            push_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            cur_bank_reg    <= cur_bank_next;
            step_count_reg  <= step_count_next;
            m_valid_reg     <= m_valid_next;
            push_reg        <= push_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        rd_ok_reg    <= rd_ok_next;
        res_cell_reg <= res_cell_next;
        m_cell_reg   <= m_cell_next;
        m_steps_reg  <= m_steps_next;
    end

endmodule

`default_nettype wire

// ===== sv/hpss_checker.sv =====
// ----------------------------------------------------------------------------
// hpss_checker
// Port-level checks of the heat plate stencil stepper, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hpss_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [hpss_pkg::VAL_W-1:0] m_cell_value,
    input logic [hpss_pkg::STEPS_W-1:0]    m_steps_done
);
    import hpss_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_value) && $stable(m_steps_done))
        else $error("result changed while stalled");

    // The block works one request at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // A result only appears after the block has been busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work");

    // Reset leaves the block idle with no pending result.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind heat_plate_stencil_stepper hpss_checker u_hpss_checker (.*);

`default_nettype wire
